// ----- rtl/dasd_pkg.sv -----
// ----------------------------------------------------------------------------
// dasd_pkg
// Shared widths, codes and calendar helpers for the date add/subtract unit.
// ----------------------------------------------------------------------------
package dasd_pkg;

    // Field widths
    localparam int OP_W        = 1;
    localparam int DAY_W       = 5;
    localparam int MONTH_W     = 4;
    localparam int YEAR_W      = 14;
    localparam int DAY_COUNT_W = 20;
    localparam int STATUS_W    = 2;

    // Default number of count bits in use
    localparam int COUNT_BITS_DEF = 20;

    // Operation codes
    localparam logic [OP_W-1:0] OP_ADD = 1'b0;
    localparam logic [OP_W-1:0] OP_SUB = 1'b1;

    // Status codes
    localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_BAD_DATE  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_YEAR_OVFL = 2'd2;

    // Calendar limits
    localparam logic [YEAR_W-1:0]  YEAR_MIN = 14'd1;
    localparam logic [YEAR_W-1:0]  YEAR_MAX = 14'd9999;
    localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
    localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;
    localparam logic [DAY_W-1:0]   DAY_FIRST = 5'd1;

    // Century split: year / 100 as (year * 5243) >> 19, exact for 14-bit years
    localparam int                 RECIP_W     = 13;
    localparam logic [RECIP_W-1:0] RECIP_100   = 13'd5243;
    localparam int                 RECIP_SHIFT = 19;
    localparam int                 PROD_W      = YEAR_W + RECIP_W;
    localparam int                 CENT_W      = PROD_W - RECIP_SHIFT;
    localparam int                 YLO_W       = 7;
    localparam logic [YLO_W-1:0]   YLO_LAST    = 7'd99;
    localparam logic [YLO_W-1:0]   HUNDRED     = 7'd100;

    // Leap rule from year[1:0], year mod 100 and century mod 4
    function automatic logic is_leap(input logic [1:0] year_lsb,
                                     input logic [YLO_W-1:0] ylo,
                                     input logic [1:0] cen);
        logic by4;
        logic cent_yr;
        by4     = (year_lsb == 2'd0);
        cent_yr = (ylo == '0);
        return (by4 && !cent_yr) || (cent_yr && (cen == 2'd0));
    endfunction

    // Month length; zero for a month code outside 1..12
    function automatic logic [DAY_W-1:0] days_in(input logic [MONTH_W-1:0] m,
                                                 input logic leap);
        logic [DAY_W-1:0] len;
        unique case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
            4'd2:                                       len = leap ? 5'd29 : 5'd28;
            default:                                    len = 5'd0;
        endcase
        return len;
    endfunction

endpackage

// ----- rtl/dasd_cmd_if.sv -----
// ----------------------------------------------------------------------------
// dasd_cmd_if
// Request channel: a date, a day count and an operation per beat.
// ----------------------------------------------------------------------------
interface dasd_cmd_if;
    logic                             valid;
    logic                             ready;
    logic [dasd_pkg::OP_W-1:0]        operation;
    logic [dasd_pkg::DAY_W-1:0]       day;
    logic [dasd_pkg::MONTH_W-1:0]     month;
    logic [dasd_pkg::YEAR_W-1:0]      year;
    logic [dasd_pkg::DAY_COUNT_W-1:0] day_count;

    modport source (output valid, operation, day, month, year, day_count,
                    input ready);
    modport sink   (input valid, operation, day, month, year, day_count,
                    output ready);
endinterface

// ----- rtl/dasd_res_if.sv -----
// ----------------------------------------------------------------------------
// dasd_res_if
// Result channel: resulting date and status per beat.
// ----------------------------------------------------------------------------
interface dasd_res_if;
    logic                          valid;
    logic                          ready;
    logic [dasd_pkg::DAY_W-1:0]    result_day;
    logic [dasd_pkg::MONTH_W-1:0]  result_month;
    logic [dasd_pkg::YEAR_W-1:0]   result_year;
    logic [dasd_pkg::STATUS_W-1:0] status;

    modport source (output valid, result_day, result_month, result_year, status,
                    input ready);
    modport sink   (input valid, result_day, result_month, result_year, status,
                    output ready);
endinterface

// ----- rtl/date_add_subtract_days_unit.sv -----
// ----------------------------------------------------------------------------
// date_add_subtract_days_unit
// Adds or subtracts a day count to a Gregorian date, one month per cycle.
// ----------------------------------------------------------------------------
// One beat on cmd gives one beat on res, and the unit takes one request at a
// time. The century multiply runs on the beat itself. The unit then passes
// through the DIV, REM and CHECK states for the year split (year-of-century
// by multiply-subtract) and the date check. It then walks the calendar one
// month per cycle through a single month-length/count update unit. The walk
// places the day inside the last month and then sees the count at zero. A
// last DONE state hands the result to the output register. An invalid date
// goes from the check straight to DONE without a walk, and a zero count
// leaves the walk before any month is crossed. cmd.ready rises again in the
// cycle after the result is loaded. The longest count walks some 34k months.
// cmd.ready is high only while the unit is idle; a finished result may wait
// in the output register while the next beat is taken.
// Invalid dates (status 1) and walks leaving years 1..9999 (status 2) echo
// the input date. Only the low COUNT_BITS bits of day_count are used.
module date_add_subtract_days_unit #(
    parameter int COUNT_BITS = dasd_pkg::COUNT_BITS_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    dasd_cmd_if.sink   cmd,
    dasd_res_if.source res
);

    localparam int CW = (COUNT_BITS < dasd_pkg::DAY_COUNT_W) ?
                        COUNT_BITS : dasd_pkg::DAY_COUNT_W;

    // Sequencer states
    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_DIV   = 3'd1;
    localparam logic [2:0] ST_REM   = 3'd2;
    localparam logic [2:0] ST_CHECK = 3'd3;
    localparam logic [2:0] ST_WALK  = 3'd4;
    localparam logic [2:0] ST_DONE  = 3'd5;

    logic [2:0] state_reg, state_next;

    // Request capture (echoed on error)
    logic [dasd_pkg::OP_W-1:0]    op_reg;
    logic [dasd_pkg::DAY_W-1:0]   d0_reg;
    logic [dasd_pkg::MONTH_W-1:0] m0_reg;
    logic [dasd_pkg::YEAR_W-1:0]  y0_reg;

    // Working date and count
    logic [dasd_pkg::DAY_W-1:0]   d_reg, d_next;
    logic [dasd_pkg::MONTH_W-1:0] m_reg, m_next;
    logic [dasd_pkg::YEAR_W-1:0]  y_reg, y_next;
    logic [CW-1:0]                cnt_reg, cnt_next;
    logic [dasd_pkg::YLO_W-1:0]   ylo_reg, ylo_next;
    logic [1:0]                   cen_reg, cen_next;
    logic [dasd_pkg::CENT_W-1:0]  q_reg;
    logic [dasd_pkg::STATUS_W-1:0] status_reg, status_next;

    // Output register
    logic                          out_valid_reg;
    logic [dasd_pkg::DAY_W-1:0]    out_day_reg;
    logic [dasd_pkg::MONTH_W-1:0]  out_month_reg;
    logic [dasd_pkg::YEAR_W-1:0]   out_year_reg;
    logic [dasd_pkg::STATUS_W-1:0] out_status_reg;

    logic                          cmd_beat;
    logic                          out_load;
    logic [dasd_pkg::PROD_W-1:0]   cent_prod;
    logic [dasd_pkg::YEAR_W-1:0]   cent_scaled;
    logic [dasd_pkg::YEAR_W-1:0]   ylo_full;
    logic                          leap;
    logic [dasd_pkg::DAY_W-1:0]    cur_len;
    logic [dasd_pkg::DAY_W-1:0]    room;
    logic [CW-1:0]                 room_ext;
    logic [CW-1:0]                 d_ext;
    logic                          date_ok;

    assign cmd_beat  = cmd.valid && cmd.ready;
    assign cmd.ready = (state_reg == ST_IDLE);
    assign out_load  = (state_reg == ST_DONE) && (!out_valid_reg || res.ready);

    // Century split datapath
    assign cent_prod   = dasd_pkg::PROD_W'(cmd.year) * dasd_pkg::PROD_W'(dasd_pkg::RECIP_100);
    assign cent_scaled = dasd_pkg::YEAR_W'(q_reg) * dasd_pkg::YEAR_W'(dasd_pkg::HUNDRED);
    assign ylo_full    = y_reg - cent_scaled;

    // Month length of the working date
    assign leap     = dasd_pkg::is_leap(y_reg[1:0], ylo_reg, cen_reg);
    assign cur_len  = dasd_pkg::days_in(m_reg, leap);
    assign room     = cur_len - d_reg;
    assign room_ext = CW'(room);
    assign d_ext    = CW'(d_reg);
    assign date_ok  = (m_reg >= dasd_pkg::MONTH_JAN) && (m_reg <= dasd_pkg::MONTH_DEC) &&
                      (y_reg >= dasd_pkg::YEAR_MIN) && (y_reg <= dasd_pkg::YEAR_MAX) &&
                      (d_reg != '0) && (d_reg <= cur_len);

    // Sequencer and month-step unit
    always_comb
    begin
        state_next  = state_reg;
        d_next      = d_reg;
        m_next      = m_reg;
        y_next      = y_reg;
        cnt_next    = cnt_reg;
        ylo_next    = ylo_reg;
        cen_next    = cen_reg;
        status_next = status_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_beat)
                begin
                    d_next      = cmd.day;
                    m_next      = cmd.month;
                    y_next      = cmd.year;
                    cnt_next    = cmd.day_count[CW-1:0];
                    status_next = dasd_pkg::STATUS_OK;
                    state_next  = ST_DIV;
                end
            end
            ST_DIV:
            begin
                state_next = ST_REM;
            end
            ST_REM:
            begin
                ylo_next   = ylo_full[dasd_pkg::YLO_W-1:0];
                cen_next   = q_reg[1:0];
                state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                if (date_ok)
                begin
                    state_next = ST_WALK;
                end
                else
                begin
                    status_next = dasd_pkg::STATUS_BAD_DATE;
                    state_next  = ST_DONE;
                end
            end
            ST_WALK:
            begin
                if (cnt_reg == '0)
                begin
                    state_next = ST_DONE;
                end
                else if (op_reg == dasd_pkg::OP_ADD)
                begin
                    if (cnt_reg > room_ext)
                    begin
                        // Cross into the next month
                        cnt_next = cnt_reg - room_ext - CW'(1);
                        d_next   = dasd_pkg::DAY_FIRST;
                        if (m_reg == dasd_pkg::MONTH_DEC)
                        begin
                            if (y_reg >= dasd_pkg::YEAR_MAX)
                            begin
                                status_next = dasd_pkg::STATUS_YEAR_OVFL;
                                state_next  = ST_DONE;
                            end
                            else
                            begin
                                m_next = dasd_pkg::MONTH_JAN;
                                y_next = y_reg + dasd_pkg::YEAR_W'(1);
                                if (ylo_reg == dasd_pkg::YLO_LAST)
                                begin
                                    ylo_next = '0;
                                    cen_next = cen_reg + 2'd1;
                                end
                                else
                                begin
                                    ylo_next = ylo_reg + dasd_pkg::YLO_W'(1);
                                end
                            end
                        end
                        else
                        begin
                            m_next = m_reg + dasd_pkg::MONTH_W'(1);
                        end
                    end
                    else
                    begin
                        d_next   = d_reg + cnt_reg[dasd_pkg::DAY_W-1:0];
                        cnt_next = '0;
                    end
                end
                else
                begin
                    if (d_ext > cnt_reg)
                    begin
                        d_next   = d_reg - cnt_reg[dasd_pkg::DAY_W-1:0];
                        cnt_next = '0;
                    end
                    else
                    begin
                        // Back into the last day of the previous month
                        cnt_next = cnt_reg - d_ext;
                        if (m_reg == dasd_pkg::MONTH_JAN)
                        begin
                            if (y_reg <= dasd_pkg::YEAR_MIN)
                            begin
                                status_next = dasd_pkg::STATUS_YEAR_OVFL;
                                state_next  = ST_DONE;
                            end
                            else
                            begin
                                m_next = dasd_pkg::MONTH_DEC;
                                y_next = y_reg - dasd_pkg::YEAR_W'(1);
                                d_next = dasd_pkg::days_in(dasd_pkg::MONTH_DEC, 1'b0);
                                if (ylo_reg == '0)
                                begin
                                    ylo_next = dasd_pkg::YLO_LAST;
                                    cen_next = cen_reg - 2'd1;
                                end
                                else
                                begin
                                    ylo_next = ylo_reg - dasd_pkg::YLO_W'(1);
                                end
                            end
                        end
                        else
                        begin
                            m_next = m_reg - dasd_pkg::MONTH_W'(1);
                            d_next = dasd_pkg::days_in(m_reg - dasd_pkg::MONTH_W'(1), leap);
                        end
                    end
                end
            end
            ST_DONE:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (res.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        d_reg      <= d_next;
        m_reg      <= m_next;
        y_reg      <= y_next;
        cnt_reg    <= cnt_next;
        ylo_reg    <= ylo_next;
        cen_reg    <= cen_next;
        status_reg <= status_next;
        if (cmd_beat)
        begin
            op_reg <= cmd.operation;
            d0_reg <= cmd.day;
            m0_reg <= cmd.month;
            y0_reg <= cmd.year;
            q_reg  <= cent_prod[dasd_pkg::PROD_W-1:dasd_pkg::RECIP_SHIFT];
        end
        if (out_load)
        begin
            out_status_reg <= status_reg;
            if (status_reg == dasd_pkg::STATUS_OK)
            begin
                out_day_reg   <= d_reg;
                out_month_reg <= m_reg;
                out_year_reg  <= y_reg;
            end
            else
            begin
                out_day_reg   <= d0_reg;
                out_month_reg <= m0_reg;
                out_year_reg  <= y0_reg;
            end
        end
    end

    assign res.valid        = out_valid_reg;
    assign res.result_day   = out_day_reg;
    assign res.result_month = out_month_reg;
    assign res.result_year  = out_year_reg;
    assign res.status       = out_status_reg;

`ifndef SYNTHESIS
    // Accepted beat always starts the century split
    a_beat_starts: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_beat |=> (state_reg == ST_DIV))
        else $error("accepted beat did not start the sequencer");

    // Walk keeps a real day and a year-of-century below one hundred
    a_walk_sane: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WALK) |-> (d_reg != '0) && (d_reg <= cur_len) &&
                                   (ylo_reg < dasd_pkg::HUNDRED))
        else $error("walk left a valid date");

    // Year-of-century tracks the year in the low two bits
    a_ylo_track: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WALK) |-> (ylo_reg[1:0] == y_reg[1:0]))
        else $error("year-of-century out of step with year");

    // A good result is a real calendar date
    a_ok_result: assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && (res.status == dasd_pkg::STATUS_OK)) |->
            (res.result_month >= dasd_pkg::MONTH_JAN) &&
            (res.result_month <= dasd_pkg::MONTH_DEC) &&
            (res.result_year >= dasd_pkg::YEAR_MIN) &&
            (res.result_year <= dasd_pkg::YEAR_MAX) &&
            (res.result_day != '0))
        else $error("ok result is not a valid date");
`endif

endmodule
